// File: hw/rtl/ssc_pkg.sv
// Shared types and constants for the subset state cache with clock replacement.
// Holds the payload structs, action codes and controller/datapath command types.
// No dependencies.
package ssc_pkg;

  localparam int SLOTS_DEF    = 64;
  localparam int KEY_BITS_DEF = 64;

  localparam int ACTION_W = 2;
  localparam int KEY_W    = 64;
  localparam int TARGET_W = 6;
  localparam int PHASE_W  = 32;
  localparam int CPHASE_W = 31;
  localparam int SLOT_W   = 6;

  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_MARK   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NOP    = 2'd3;

  // phase value of an entry that has not been used yet (-1)
  localparam logic [PHASE_W-1:0] PHASE_UNUSED = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ACTION_W-1:0]       action;
    logic [KEY_W-1:0]          key;
    logic                      mark_initial;
    logic [TARGET_W-1:0]       target_slot;
    logic signed [PHASE_W-1:0] entry_phase;
    logic                      chance;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              hit;
    logic              replaced;
    logic              no_victim;
  } out_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN,
    OP_HIT,
    OP_FILL_FREE,
    OP_SWEEP_BEGIN,
    OP_SWEEP_ADV,
    OP_SWEEP_CHANCE,
    OP_VICTIM,
    OP_NO_VICTIM,
    OP_MARK,
    OP_CLEAR_STEP,
    OP_ZERO,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                scan_left;
    logic                cmp_pending;
    logic                cmp_hit;
    logic                full;
    logic                wrap_hit;
    logic                wrapped;
    logic                protect;
    logic                chance_set;
  } status_t;

endpackage

// File: hw/rtl/subset_state_cache_clock_replace.sv
// Top level of the subset state cache with clock second-chance replacement.
// Joins the controller and the datapath. Depends on ssc_pkg, ssc_ctrl, ssc_dp.
//
//   channel | signals                         | beat
//   --------+---------------------------------+------------------------------
//   input   | in_valid, in_ready, in_data     | one action with its fields
//   output  | out_valid, out_ready, out_data  | slot, hit, replaced, no_victim
//   config  | cfg_wr_en, cfg_wr_data          | current_phase, one cycle write
//
// Mark and no-op go from dispatch straight to finish; clear steps through each used entry.
// Lookup walks the key RAM one entry a cycle: a hit stops at its slot, a miss walks every
// used entry first (none when empty); when full, each swept slot is an advance
// with RAM read, then an evaluate, for up to two rounds, ending in a victim or no victim.
// Reset is synchronous with no clearing pass; a fill count tracks use. A stalled
// result waits in the output register while the next beat is taken and worked on.
module subset_state_cache_clock_replace #(
  parameter int SLOTS    = ssc_pkg::SLOTS_DEF,
  parameter int KEY_BITS = ssc_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  ssc_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output ssc_pkg::out_t                out_data,
  input  logic                         cfg_wr_en,
  input  logic [ssc_pkg::CPHASE_W-1:0] cfg_wr_data
);

  ssc_pkg::cmd_t    cmd;
  ssc_pkg::status_t status;

  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ssc_dp #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

// File: hw/rtl/ssc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/ssc_ctrl.sv
// Controller for the subset state cache: sequences lookup, fill, clock sweep,
// mark and clear over the datapath. Depends on ssc_pkg.
module ssc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  ssc_pkg::status_t status,
  output ssc_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOKUP,
    S_SWEEP_ADV,
    S_SWEEP_EVAL,
    S_CLEAR,
    S_FINISH
  } state_t;

  state_t state, state_next;
  ssc_pkg::dp_op_t op;

  assign in_ready = (state == S_IDLE);
  assign cmd.op   = op;

  always_comb begin
    op         = ssc_pkg::OP_NOP;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = ssc_pkg::OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.action)
          ssc_pkg::ACT_LOOKUP: state_next = S_LOOKUP;
          ssc_pkg::ACT_MARK: begin
            op         = ssc_pkg::OP_MARK;
            state_next = S_FINISH;
          end
          ssc_pkg::ACT_CLEAR: state_next = S_CLEAR;
          default: begin
            op         = ssc_pkg::OP_ZERO;
            state_next = S_FINISH;
          end
        endcase
      end
      S_LOOKUP: begin
        if (status.cmp_hit) begin
          op         = ssc_pkg::OP_HIT;
          state_next = S_FINISH;
        end else if (status.scan_left) begin
          op = ssc_pkg::OP_SCAN;
        end else if (status.cmp_pending) begin
          // drain the last compare
          op = ssc_pkg::OP_NOP;
        end else if (!status.full) begin
          op         = ssc_pkg::OP_FILL_FREE;
          state_next = S_FINISH;
        end else begin
          op         = ssc_pkg::OP_SWEEP_BEGIN;
          state_next = S_SWEEP_ADV;
        end
      end
      S_SWEEP_ADV: begin
        if (status.wrap_hit && status.wrapped) begin
          op         = ssc_pkg::OP_NO_VICTIM;
          state_next = S_FINISH;
        end else begin
          op         = ssc_pkg::OP_SWEEP_ADV;
          state_next = S_SWEEP_EVAL;
        end
      end
      S_SWEEP_EVAL: begin
        if (status.protect) begin
          state_next = S_SWEEP_ADV;
        end else if (status.chance_set) begin
          op         = ssc_pkg::OP_SWEEP_CHANCE;
          state_next = S_SWEEP_ADV;
        end else begin
          op         = ssc_pkg::OP_VICTIM;
          state_next = S_FINISH;
        end
      end
      S_CLEAR: begin
        if (status.scan_left) begin
          op = ssc_pkg::OP_CLEAR_STEP;
        end else begin
          op         = ssc_pkg::OP_ZERO;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          op         = ssc_pkg::OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == ssc_pkg::OP_PUSH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/ssc_dp.sv
// Datapath for the subset state cache: entry RAMs, key compare, clock hand,
// fill count, phase protection check and result registers.
// Depends on ssc_pkg and ssc_ram.
module ssc_dp #(
  parameter int SLOTS    = ssc_pkg::SLOTS_DEF,
  parameter int KEY_BITS = ssc_pkg::KEY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ssc_pkg::in_t                  in_data,
  output ssc_pkg::out_t                 out_data,
  input  logic                          cfg_wr_en,
  input  logic [ssc_pkg::CPHASE_W-1:0]  cfg_wr_data,
  input  ssc_pkg::cmd_t                 cmd,
  output ssc_pkg::status_t              status
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int PW    = ssc_pkg::PHASE_W;

  // latched item
  logic [ssc_pkg::ACTION_W-1:0] item_action;
  logic [KEY_BITS-1:0]          item_key;
  logic                         item_init;
  logic [ssc_pkg::TARGET_W-1:0] item_target;
  logic [PW-1:0]                item_phase;
  logic                         item_chance;

  logic [CNT_W-1:0]             used;
  logic [IDX_W-1:0]             hand;
  logic [IDX_W-1:0]             start;
  logic                         wrapped;
  logic [CNT_W-1:0]             idx;
  logic                         cmp_v;
  logic [IDX_W-1:0]             cmp_idx;
  logic [ssc_pkg::CPHASE_W-1:0] current_phase;
  ssc_pkg::out_t                res;

  logic [KEY_BITS-1:0] key_rd;
  logic [PW-1:0]       phase_rd;
  logic                chance_rd;
  logic                init_rd;

  logic [IDX_W-1:0] hand_adv;
  logic [IDX_W-1:0] fill_slot;
  logic [IDX_W-1:0] target_idx;
  logic             target_ok;
  logic             do_fill;
  logic             do_mark;
  logic signed [PW+1:0] phase_ext;
  logic signed [PW+1:0] cp_ext;
  logic signed [PW+1:0] phase_diff;

  logic             key_we, phase_we, chance_we, init_we;
  logic [IDX_W-1:0] phase_wa, chance_wa;
  logic [PW-1:0]    phase_wd;
  logic             chance_wd;
  logic             key_re, sweep_re;

  assign hand_adv   = (hand == IDX_W'(SLOTS - 1)) ? '0 : hand + IDX_W'(1);
  assign fill_slot  = (cmd.op == ssc_pkg::OP_VICTIM) ? hand : used[IDX_W-1:0];
  assign target_idx = IDX_W'(item_target);
  assign target_ok  = (32'(item_target) < 32'(SLOTS));
  assign do_fill    = (cmd.op == ssc_pkg::OP_FILL_FREE) || (cmd.op == ssc_pkg::OP_VICTIM);
  assign do_mark    = (cmd.op == ssc_pkg::OP_MARK) && target_ok;

  // phase within one of the current phase, compared two bits wider
  assign phase_ext  = {{2{phase_rd[PW-1]}}, phase_rd};
  assign cp_ext     = {3'b000, current_phase};
  assign phase_diff = phase_ext - cp_ext;

  always_comb begin
    key_we    = do_fill;
    key_re    = (cmd.op == ssc_pkg::OP_SCAN);
    sweep_re  = (cmd.op == ssc_pkg::OP_SWEEP_ADV);
    init_we   = do_fill;

    phase_we  = 1'b0;
    phase_wa  = fill_slot;
    phase_wd  = ssc_pkg::PHASE_UNUSED;
    if (do_fill) begin
      phase_we = 1'b1;
    end else if (do_mark) begin
      phase_we = 1'b1;
      phase_wa = target_idx;
      phase_wd = item_phase;
    end else if (cmd.op == ssc_pkg::OP_CLEAR_STEP) begin
      phase_we = 1'b1;
      phase_wa = idx[IDX_W-1:0];
    end

    chance_we = 1'b0;
    chance_wa = fill_slot;
    chance_wd = 1'b0;
    if (do_fill) begin
      chance_we = 1'b1;
    end else if (do_mark) begin
      chance_we = 1'b1;
      chance_wa = target_idx;
      chance_wd = item_chance;
    end else if (cmd.op == ssc_pkg::OP_SWEEP_CHANCE) begin
      chance_we = 1'b1;
      chance_wa = hand;
    end
  end

  ssc_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
    .clk     (clk),
    .wr_en   (key_we),
    .wr_addr (fill_slot),
    .wr_data (item_key),
    .rd_en   (key_re),
    .rd_addr (idx[IDX_W-1:0]),
    .rd_data (key_rd)
  );

  ssc_ram #(.WIDTH(PW), .DEPTH(SLOTS)) u_phase_ram (
    .clk     (clk),
    .wr_en   (phase_we),
    .wr_addr (phase_wa),
    .wr_data (phase_wd),
    .rd_en   (sweep_re),
    .rd_addr (hand_adv),
    .rd_data (phase_rd)
  );

  ssc_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_chance_ram (
    .clk     (clk),
    .wr_en   (chance_we),
    .wr_addr (chance_wa),
    .wr_data (chance_wd),
    .rd_en   (sweep_re),
    .rd_addr (hand_adv),
    .rd_data (chance_rd)
  );

  ssc_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_init_ram (
    .clk     (clk),
    .wr_en   (init_we),
    .wr_addr (fill_slot),
    .wr_data (item_init),
    .rd_en   (sweep_re),
    .rd_addr (hand_adv),
    .rd_data (init_rd)
  );

  always_comb begin
    status.action      = item_action;
    status.scan_left   = (idx < used);
    status.cmp_pending = cmp_v;
    status.cmp_hit     = cmp_v && (key_rd == item_key);
    status.full        = (used == CNT_W'(SLOTS));
    status.wrap_hit    = (hand_adv == start);
    status.wrapped     = wrapped;
    status.protect     = init_rd || (phase_rd == ssc_pkg::PHASE_UNUSED) ||
                         (phase_diff == '0) || (phase_diff == (PW+2)'(1)) ||
                         (phase_diff == '1);
    status.chance_set  = chance_rd;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      hand          <= '0;
      wrapped       <= 1'b0;
      idx           <= '0;
      cmp_v         <= 1'b0;
      current_phase <= '0;
    end else begin
      if (cfg_wr_en) begin
        current_phase <= cfg_wr_data;
      end
      cmp_v <= (cmd.op == ssc_pkg::OP_SCAN);
      case (cmd.op)
        ssc_pkg::OP_LOAD:       idx <= '0;
        ssc_pkg::OP_SCAN:       idx <= idx + CNT_W'(1);
        ssc_pkg::OP_CLEAR_STEP: idx <= idx + CNT_W'(1);
        ssc_pkg::OP_FILL_FREE:  used <= used + CNT_W'(1);
        ssc_pkg::OP_SWEEP_ADV: begin
          hand <= hand_adv;
          if (hand_adv == start) begin
            wrapped <= 1'b1;
          end
        end
        ssc_pkg::OP_NO_VICTIM: begin
          hand    <= hand_adv;
          wrapped <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == ssc_pkg::OP_SCAN) begin
      cmp_idx <= idx[IDX_W-1:0];
    end
    case (cmd.op)
      ssc_pkg::OP_LOAD: begin
        item_action <= in_data.action;
        item_key    <= in_data.key[KEY_BITS-1:0];
        item_init   <= in_data.mark_initial;
        item_target <= in_data.target_slot;
        item_phase  <= in_data.entry_phase;
        item_chance <= in_data.chance;
      end
      ssc_pkg::OP_HIT: begin
        res <= '{slot: ssc_pkg::SLOT_W'(cmp_idx), hit: 1'b1, replaced: 1'b0,
                 no_victim: 1'b0};
      end
      ssc_pkg::OP_FILL_FREE: begin
        res <= '{slot: ssc_pkg::SLOT_W'(used[IDX_W-1:0]), hit: 1'b0, replaced: 1'b0,
                 no_victim: 1'b0};
      end
      ssc_pkg::OP_SWEEP_BEGIN: start <= hand;
      ssc_pkg::OP_VICTIM: begin
        res <= '{slot: ssc_pkg::SLOT_W'(hand), hit: 1'b0, replaced: 1'b1,
                 no_victim: 1'b0};
      end
      ssc_pkg::OP_NO_VICTIM: begin
        res <= '{slot: '0, hit: 1'b0, replaced: 1'b0, no_victim: 1'b1};
      end
      ssc_pkg::OP_MARK: res <= '0;
      ssc_pkg::OP_ZERO: res <= '0;
      ssc_pkg::OP_PUSH: out_data <= res;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ssc_checker.sv
// Port-level checks for the subset state cache, bound to the top level.
// Depends on ssc_pkg and subset_state_cache_clock_replace.
module ssc_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input ssc_pkg::out_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // one beat in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a beat is in work");

  // no-victim result carries no slot, hit or replace
  a_no_victim: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.no_victim |->
      out_data.slot == '0 && !out_data.hit && !out_data.replaced)
    else $error("no_victim result with other flags");

  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind subset_state_cache_clock_replace ssc_checker u_ssc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/tb_subset_state_cache_clock_replace.sv
// Testbench for subset_state_cache_clock_replace: lookups, inserts, marks and clears are
// predicted beat by beat and every reply is checked in order, under random handshake gaps.
// Depends on ssc_pkg and the RTL of the block; self-contained otherwise.
module tb_subset_state_cache_clock_replace;
  timeunit 1ns;
  timeprecision 1ps;

  import ssc_pkg::*;

  localparam int NSLOT          = SLOTS_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 8;

  logic          clk;
  logic          rst         = 1'b1;
  logic          in_valid    = 1'b0;
  logic          in_ready;
  in_t           in_data     = '0;
  logic          out_valid;
  logic          out_ready   = 1'b0;
  out_t          out_data;
  logic          cfg_wr_en   = 1'b0;
  logic [CPHASE_W-1:0] cfg_wr_data = '0;

  // cache mirror
  logic [KEY_W-1:0]          slot_key   [NSLOT];
  logic signed [PHASE_W-1:0] slot_phase [NSLOT];
  bit                        slot_chance[NSLOT];
  bit                        slot_init  [NSLOT];
  int                        used_slots   = 0;
  int                        hand         = 0;
  bit                        hand_wrapped = 1'b0;
  logic [CPHASE_W-1:0]       cur_phase    = '0;

  out_t             cache_replies_q[$];
  logic [KEY_W-1:0] recent_keys[$];
  int               reply_errors = 0;
  int               tx_idle_pct  = 0;
  int               rx_stall_pct = 0;
  int               rx_hold_len  = 0;
  int               idle_cycles  = 0;

  subset_state_cache_clock_replace dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fill_slot(input int s, input in_t b);
    slot_key[s]    = b.key;
    slot_phase[s]  = -1;
    slot_chance[s] = 1'b0;
    slot_init[s]   = b.mark_initial;
  endfunction

  // Advance the hand until an unprotected entry without a second chance turns up, or two rounds pass.
  function automatic int sweep_clock_hand();
    int     start;
    longint ep;
    longint cp;
    start = hand;
    cp    = longint'(cur_phase);
    while (1'b1) begin
      hand = (hand + 1) % NSLOT;
      if (hand == start) begin
        if (hand_wrapped) begin
          hand_wrapped = 1'b0;
          return -1;
        end
        hand_wrapped = 1'b1;
      end
      ep = slot_phase[hand];
      if (ep == cp + 1 || ep == cp || ep == cp - 1 || ep == -1 || slot_init[hand])
        continue;
      if (slot_chance[hand])
        slot_chance[hand] = 1'b0;
      else
        return hand;
    end
    return -1;
  endfunction

  function automatic out_t predict_cache_reply(input in_t b);
    out_t r;
    int   found;
    int   victim;
    r     = '0;
    found = -1;
    case (b.action)
      ACT_LOOKUP: begin
        for (int i = 0; i < used_slots; i++)
          if (found < 0 && slot_key[i] == b.key) found = i;
        if (found >= 0) begin
          r.slot = SLOT_W'(found);
          r.hit  = 1'b1;
        end else if (used_slots < NSLOT) begin
          fill_slot(used_slots, b);
          r.slot = SLOT_W'(used_slots);
          used_slots++;
        end else begin
          victim = sweep_clock_hand();
          if (victim < 0) begin
            r.no_victim = 1'b1;
          end else begin
            fill_slot(victim, b);
            r.slot     = SLOT_W'(victim);
            r.replaced = 1'b1;
          end
        end
      end
      ACT_MARK: begin
        slot_phase[b.target_slot]  = b.entry_phase;
        slot_chance[b.target_slot] = b.chance;
      end
      ACT_CLEAR: begin
        for (int i = 0; i < used_slots; i++) slot_phase[i] = -1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_t beat(input logic [ACTION_W-1:0] action, input logic [KEY_W-1:0] key,
                               input logic init, input int target,
                               input logic [PHASE_W-1:0] phase, input logic chance);
    in_t b;
    b.action       = action;
    b.key          = key;
    b.mark_initial = init;
    b.target_slot  = TARGET_W'(target);
    b.entry_phase  = phase;
    b.chance       = chance;
    return b;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    return {$urandom, $urandom};
  endfunction

  // Mostly lookups and marks; mark phases cluster around the current phase edges.
  function automatic in_t random_beat();
    in_t    b;
    int     pick;
    longint cp;
    longint ph;
    b = beat(ACT_NOP, fresh_key(), $urandom_range(99) < 3, $urandom_range(NSLOT - 1),
             $urandom, 1'($urandom_range(1)));
    cp   = longint'(cur_phase);
    pick = $urandom_range(99);
    if (pick < 46) begin
      b.action = ACT_LOOKUP;
      if (recent_keys.size() != 0 && $urandom_range(1) == 1) begin
        b.key = recent_keys[$urandom_range(recent_keys.size() - 1)];
      end else begin
        recent_keys.push_back(b.key);
        if (recent_keys.size() > 48) void'(recent_keys.pop_front());
      end
    end else if (pick < 92) begin
      b.action = ACT_MARK;
      ph = cp;
      case ($urandom_range(9))
        0: ph = cp - 1;
        1: ph = cp;
        2: ph = cp + 1;
        3: ph = -1;
        4: ph = cp + 2;
        5: ph = cp - 2;
        default: ph = longint'(b.entry_phase);
      endcase
      b.entry_phase = ph[PHASE_W-1:0];
    end else if (pick < 96) begin
      b.action = ACT_CLEAR;
    end
    return b;
  endfunction

  task automatic send_beat(input in_t b);
    int gap;
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    cache_replies_q.push_back(predict_cache_reply(b));
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the input until every reply is back, then let the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (cache_replies_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_phase(input logic [CPHASE_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_phase  = v;
  endtask

  task automatic test_directed_fields();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_phase('0);
    send_beat(beat(ACT_LOOKUP, '0, 1'b1, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, '1, 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, '0, 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, '1, 1'b0, 0, '0, 1'b0));
    // mark a slot that is still free; filling it later must reset it
    send_beat(beat(ACT_MARK, '0, 1'b0, NSLOT - 1, 32'd1000, 1'b1));
    send_beat(beat(ACT_MARK, '0, 1'b0, 1, 32'h7FFF_FFFF, 1'b1));
    send_beat(beat(ACT_MARK, '0, 1'b0, 0, 32'h8000_0000, 1'b0));
    send_beat(beat(ACT_NOP, '1, 1'b1, NSLOT - 1, 32'hFFFF_FFFF, 1'b1));
    send_beat(beat(ACT_CLEAR, '1, 1'b1, NSLOT - 1, '1, 1'b1));
    send_beat(beat(ACT_LOOKUP, {16{4'hA}}, 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, {16{4'h5}}, 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, {16{4'hA}}, 1'b1, NSLOT - 1, '1, 1'b1));
    send_beat(beat(ACT_MARK, '0, 1'b0, 2, 32'd0, 1'b0));
    send_beat(beat(ACT_CLEAR, '0, 1'b0, 0, '0, 1'b0));
    drain_results();
  endtask

  task automatic test_fill_store();
    tx_idle_pct  = 6;
    rx_stall_pct = 6;
    while (used_slots < NSLOT)
      send_beat(beat(ACT_LOOKUP, fresh_key(), 1'b0, 0, $urandom, 1'b0));
    drain_results();
  endtask

  task automatic test_replacement_cases();
    logic [KEY_W-1:0] k;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    // every entry unused or initial: nothing can be evicted
    send_beat(beat(ACT_LOOKUP, fresh_key(), 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, fresh_key(), 1'b0, 0, '0, 1'b0));
    drain_results();
    write_phase('1);
    send_beat(beat(ACT_MARK, '0, 1'b0, 5, 32'h8000_0000, 1'b0));
    send_beat(beat(ACT_MARK, '0, 1'b0, 6, 32'h7FFF_FFFE, 1'b1));
    send_beat(beat(ACT_MARK, '0, 1'b0, 7, 32'h7FFF_FFFF, 1'b0));
    send_beat(beat(ACT_MARK, '0, 1'b0, 0, 32'd5, 1'b0));
    send_beat(beat(ACT_MARK, '0, 1'b0, 8, 32'd100, 1'b1));
    k = fresh_key();
    send_beat(beat(ACT_LOOKUP, k, 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, fresh_key(), 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, fresh_key(), 1'b0, 0, '0, 1'b0));
    send_beat(beat(ACT_LOOKUP, k, 1'b0, 0, '0, 1'b0));
    drain_results();
  endtask

  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_phase(31'd12);
    rx_hold_len = 400;
    repeat (24) send_beat(random_beat());
    drain_results();
  endtask

  task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct,
                                     input logic [CPHASE_W-1:0] phase);
    write_phase(phase);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (count) send_beat(random_beat());
    drain_results();
  endtask

  always @(posedge clk) begin : reply_check
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (cache_replies_q.size() == 0) begin
        reply_errors++;
        if (reply_errors <= 100)
          $display("%0t: unexpected reply, expected none, got slot=%0d hit=%0b repl=%0b nv=%0b",
                   $time, out_data.slot, out_data.hit, out_data.replaced, out_data.no_victim);
      end else begin
        want = cache_replies_q.pop_front();
        if (out_data.slot !== want.slot || out_data.hit !== want.hit ||
            out_data.replaced !== want.replaced || out_data.no_victim !== want.no_victim) begin
          reply_errors++;
          if (reply_errors <= 100)
            $display("%0t: reply mismatch, expected slot=%0d hit=%0b repl=%0b nv=%0b, %s%0d %0b %0b %0b",
                     $time, want.slot, want.hit, want.replaced, want.no_victim,
                     "got slot/hit/repl/nv=", out_data.slot, out_data.hit,
                     out_data.replaced, out_data.no_victim);
        end
      end
    end
    // a requested hold-off keeps ready low until its count runs out
    if (rx_hold_len != 0) begin
      out_ready   <= 1'b0;
      rx_hold_len <= rx_hold_len - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_directed_fields();
    test_fill_store();
    test_replacement_cases();
    test_backpressure();
    test_random_traffic(480, 0, 0, '0);
    test_random_traffic(480, 73, 0, 31'h7FFF_FFFF);
    test_random_traffic(480, 0, 73, 31'd1);
    test_random_traffic(480, 6, 6, CPHASE_W'($urandom));
    if (reply_errors == 0 && cache_replies_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
